### sv/mhst_pkg.sv
// ----------------------------------------------------------------------------
// mhst_pkg
// Shared types and constants for the multiplicative hash slot table.
// ----------------------------------------------------------------------------
package mhst_pkg;

  // Field widths of one input word and one result word.
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned MULT_W  = 32;

  // Reset value of the Q0.32 hash multiplier, about 0.618033.
  localparam logic [MULT_W-1:0] MULT_RESET = 32'd2654431523;

  // Operation codes. The fourth code has no meaning and is served by default arms.
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture an accepted input word
    logic mul;     // register the Q0.32 hash fraction
    logic scale;   // register the hashed slot
    logic read;    // read the addressed table entry
    logic update;  // write back the entry and load the result register
    logic clear;   // clear the entry under the clearing counter
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic new_insert;  // the word offered on the input is an insert
    logic clr_last;    // the clearing counter is on the last entry
  } status_t;

endpackage

### sv/mhst_ctrl.sv
// ----------------------------------------------------------------------------
// mhst_ctrl
// Sequencer for the slot table: clearing pass, hash steps, table read and
// write-back, and the output valid flag.
// ----------------------------------------------------------------------------
module mhst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  mhst_pkg::status_t status_i,
  output mhst_pkg::cmd_t    cmd_o
);
  import mhst_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_READ,
    ST_UPDATE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   res_free;

  // The result register can take a new word when it is empty or being drained.
  assign res_free = !out_valid_q || !out_stall_i;

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.new_insert ? ST_MUL : ST_READ;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (res_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and the registered output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### sv/mhst_dpath.sv
// ----------------------------------------------------------------------------
// mhst_dpath
// Datapath of the slot table: multiplier register, hash multiply and scale,
// the entry memory with its clearing counter, and the result register.
// ----------------------------------------------------------------------------
module mhst_dpath #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mhst_pkg::MULT_W-1:0]    cfg_wdata_i,
  input  logic [mhst_pkg::MODE_W-1:0]    mode_i,
  input  logic [mhst_pkg::VALUE_W-1:0]   item_value_i,
  input  logic [mhst_pkg::IDX_W-1:0]     slot_index_i,
  input  mhst_pkg::cmd_t                 cmd_i,
  output mhst_pkg::status_t              status_o,
  output logic [mhst_pkg::IDX_W-1:0]     slot_used_o,
  output logic                           was_present_o,
  output logic [mhst_pkg::VALUE_W-1:0]   stored_value_o
);
  import mhst_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SW = IW + 1;
  localparam int unsigned PW = MULT_W + SW;
  localparam int unsigned EW = VALUE_W + 1;
  localparam logic [PW-1:0] SLOTS_P = PW'(SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  logic [MULT_W-1:0]  mult_q;
  logic [MODE_W-1:0]  mode_q;
  logic [VALUE_W-1:0] value_q;
  logic [IDX_W-1:0]   idx_q;
  logic [MULT_W-1:0]  frac_q;
  logic [IW-1:0]      slot_q;
  logic [IW-1:0]      clr_q;
  logic [EW-1:0]      rdata_q;
  logic [EW-1:0]      mem_q [SLOTS];

  logic [IDX_W-1:0]   used_q;
  logic               present_q;
  logic [VALUE_W-1:0] found_q;

  logic [MULT_W-1:0]  frac_d;
  logic [PW-1:0]      scaled;
  logic [IW-1:0]      idx_addr;
  logic               in_range;
  logic               is_insert;
  logic [IW-1:0]      addr;
  logic               present;
  logic               upd_we;
  logic [EW-1:0]      upd_data;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [EW-1:0]      mem_wdata;
  logic [IDX_W-1:0]   used_d;
  logic [VALUE_W-1:0] found_d;

  // Hash multiplier register, written whenever the port asks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MULT_RESET;
    end else if (cfg_we_i) begin
      mult_q <= cfg_wdata_i;
    end
  end

  // Clearing counter that walks the table once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign status_o.clr_last   = (clr_q == LAST_SLOT);
  assign status_o.new_insert = (mode_e'(mode_i) == MODE_INSERT);

  // The fraction keeps the low word of value times multiplier; the slot is the
  // integer part of that fraction scaled by the table size.
  assign frac_d = 32'(value_q) * mult_q;
  assign scaled = PW'(frac_q) * SLOTS_P;

  // Input capture and the two hash stages.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      value_q <= item_value_i;
      idx_q   <= slot_index_i;
    end
    if (cmd_i.mul) begin
      frac_q <= frac_d;
    end
    if (cmd_i.scale) begin
      slot_q <= scaled[PW-2:MULT_W];
    end
  end

  // A given slot beyond the table counts as empty.
  assign idx_addr  = IW'(idx_q);
  assign in_range  = (32'(idx_q) < 32'(SLOTS));
  assign is_insert = (mode_e'(mode_q) == MODE_INSERT);
  assign addr      = is_insert ? slot_q : idx_addr;
  assign present   = rdata_q[EW-1] && (is_insert || in_range);

  // Write-back and result fields by operation.
  always_comb begin
    upd_we   = 1'b0;
    upd_data = rdata_q;
    used_d   = idx_q;
    found_d  = '0;
    case (mode_e'(mode_q))
      MODE_INSERT: begin
        upd_we   = 1'b1;
        upd_data = {1'b1, value_q};
        used_d   = IDX_W'(slot_q);
      end
      MODE_SEARCH: begin
        if (present) begin
          found_d = rdata_q[VALUE_W-1:0];
        end
      end
      MODE_REMOVE: begin
        upd_we   = present;
        upd_data = {1'b0, rdata_q[VALUE_W-1:0]};
      end
      default: begin
        upd_we = 1'b0;
      end
    endcase
  end

  assign mem_we    = cmd_i.clear || (cmd_i.update && upd_we);
  assign mem_waddr = cmd_i.clear ? clr_q : addr;
  assign mem_wdata = cmd_i.clear ? '0 : upd_data;

  // Entry memory: valid mark over the stored value, one write and one read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      used_q    <= used_d;
      present_q <= present && (mode_e'(mode_q) == MODE_INSERT ||
                               mode_e'(mode_q) == MODE_SEARCH ||
                               mode_e'(mode_q) == MODE_REMOVE);
      found_q   <= found_d;
    end
  end

  assign slot_used_o    = used_q;
  assign was_present_o  = present_q;
  assign stored_value_o = found_q;

endmodule

### sv/multiplicative_hash_slot_table.sv
// ----------------------------------------------------------------------------
// multiplicative_hash_slot_table
// Direct slot table addressed by a Q0.32 multiplicative hash.
// ----------------------------------------------------------------------------
// Each accepted word is one operation and gives one result word. Insert hashes
// the value to slot = floor(SLOTS * frac(value * hash_multiplier)) and stores
// it there, replacing any old entry; search returns the entry of a given slot
// with its valid mark; remove clears that mark. An insert presents its result
// after fraction multiply, scale by SLOTS, table read and write-back, any
// other operation after table read and write-back. The table read is
// registered and followed by a separate write-back step. The next word is
// accepted in the cycle after the write-back, so an operation holds the block
// until its write-back is done. A waiting result sits in an output register,
// so the next word is accepted while it waits but holds in its write-back
// step until the register drains. After reset the table is cleared one entry
// per cycle while in_stall_o is high; hash multiplier writes are taken at any
// time.
// ----------------------------------------------------------------------------
module multiplicative_hash_slot_table #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mhst_pkg::MULT_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mhst_pkg::MODE_W-1:0]    mode_i,
  input  logic [mhst_pkg::VALUE_W-1:0]   item_value_i,
  input  logic [mhst_pkg::IDX_W-1:0]     slot_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mhst_pkg::IDX_W-1:0]     slot_used_o,
  output logic                           was_present_o,
  output logic [mhst_pkg::VALUE_W-1:0]   stored_value_o
);
  import mhst_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  mhst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hash, table and result register.
  mhst_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mode_i         (mode_i),
    .item_value_i   (item_value_i),
    .slot_index_i   (slot_index_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .slot_used_o    (slot_used_o),
    .was_present_o  (was_present_o),
    .stored_value_o (stored_value_o)
  );

endmodule
